>>> rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg
// Types, widths and helpers shared by the frustum box culling pipeline.
// ----------------------------------------------------------------------------
package fbc_pkg;

  // Field and arithmetic widths.
  localparam int EntryW     = 24;  // matrix entry, Q8.16
  localparam int CoordW     = 24;  // box coordinate, Q16.8
  localparam int NormW      = 25;  // plane component, exact Q9.16 sum
  localparam int ProdW      = 49;  // plane component times coordinate
  localparam int SumW       = 52;  // three products plus scaled w term
  localparam int WShift     = 8;   // aligns w from Q.16 to Q.24
  localparam int NumPlanes  = 6;
  localparam int NumAxes    = 3;
  localparam int MatEntries = 16;
  localparam int IdxW       = 4;

  // Stream payload widths.
  localparam int InDataW  = 176;
  localparam int OutDataW = 8;

  // Item kind carried on tuser.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef logic signed [EntryW-1:0] entry_t;
  typedef entry_t [MatEntries-1:0]  mat_t;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [NumAxes-1:0]     vec_t;

  typedef struct packed {
    vec_t lo;
    vec_t hi;
  } box_t;

  typedef logic signed [NormW-1:0] norm_t;
  typedef norm_t [NumAxes-1:0]     normv_t;

  // One clip plane with its chosen positive vertex.
  typedef struct packed {
    normv_t n;
    vec_t   v;
    norm_t  w;
  } plane_t;
  typedef plane_t [NumPlanes-1:0] plane_set_t;

  typedef logic signed [ProdW-1:0] prod_t;
  typedef prod_t [NumAxes-1:0]     prodv_t;

  // Registered products of one plane together with its w term.
  typedef struct packed {
    prodv_t p;
    norm_t  w;
  } term_t;
  typedef term_t [NumPlanes-1:0] term_set_t;

  // Pipeline control passed between stages.
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

  // Matrix position of a column and a row.
  function automatic logic [IdxW-1:0] mat_idx(input logic [1:0] col, input logic [1:0] row);
    mat_idx = {col, row};
  endfunction

endpackage

>>> rtl/fbc_matrix_store.sv
// ----------------------------------------------------------------------------
// fbc_matrix_store
// Sixteen-entry register file holding the view-projection matrix.
// ----------------------------------------------------------------------------
module fbc_matrix_store
  import fbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [IdxW-1:0]     waddr,
  input  entry_t              wdata,
  output mat_t                mat
);

  mat_t mat_r;

  // Entries clear to zero at reset and take one write per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (we) begin
      mat_r[waddr] <= wdata;
    end
  end

  assign mat = mat_r;

endmodule

>>> rtl/fbc_plane_setup.sv
// ----------------------------------------------------------------------------
// fbc_plane_setup
// Builds the six clip planes from the matrix and picks each positive vertex.
// ----------------------------------------------------------------------------
module fbc_plane_setup
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl_in,
  input  mat_t        mat,
  input  box_t        box,
  output stage_ctl_t  ctl_out,
  output plane_set_t  planes
);

  plane_set_t planes_nxt;
  plane_set_t planes_r;
  logic       valid_r;

  // Plane P is row 3 plus (even P) or minus (odd P) row P/2.
  for (genvar gp = 0; gp < NumPlanes; gp++) begin : g_plane
    localparam logic [1:0] Row   = 2'(gp / 2);
    localparam bit         Minus = (gp % 2) != 0;

    for (genvar gc = 0; gc < NumAxes; gc++) begin : g_axis
      entry_t a;
      entry_t b;
      norm_t  n;

      assign a = mat[mat_idx(2'(gc), 2'd3)];
      assign b = mat[mat_idx(2'(gc), Row)];
      assign n = Minus ? (NormW'(a) - NormW'(b)) : (NormW'(a) + NormW'(b));

      // A non-negative component takes the upper corner.
      assign planes_nxt[gp].n[gc] = n;
      assign planes_nxt[gp].v[gc] = n[NormW-1] ? box.lo[gc] : box.hi[gc];
    end

    entry_t wa;
    entry_t wb;
    assign wa = mat[mat_idx(2'd3, 2'd3)];
    assign wb = mat[mat_idx(2'd3, Row)];
    assign planes_nxt[gp].w = Minus ? (NormW'(wa) - NormW'(wb)) : (NormW'(wa) + NormW'(wb));
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_in.en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      planes_r <= planes_nxt;
    end
  end

  assign ctl_out.en    = ctl_in.en;
  assign ctl_out.valid = valid_r;
  assign planes        = planes_r;

endmodule

>>> rtl/fbc_plane_eval.sv
// ----------------------------------------------------------------------------
// fbc_plane_eval
// Multiplies each plane by its vertex, then sums and tests all six signs.
// ----------------------------------------------------------------------------
module fbc_plane_eval
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_ctl_t  ctl_in,
  input  plane_set_t  planes,
  output stage_ctl_t  ctl_out,
  output logic        visible
);

  term_set_t             terms_nxt;
  term_set_t             terms_r;
  logic                  valid_r;
  logic [NumPlanes-1:0]  plane_ok;

  // Eighteen independent products, one per plane and axis.
  for (genvar gp = 0; gp < NumPlanes; gp++) begin : g_mul
    for (genvar gc = 0; gc < NumAxes; gc++) begin : g_axis
      assign terms_nxt[gp].p[gc] = ProdW'(planes[gp].n[gc]) * ProdW'(planes[gp].v[gc]);
    end
    assign terms_nxt[gp].w = planes[gp].w;
  end

  // Product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_in.en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.en) begin
      terms_r <= terms_nxt;
    end
  end

  // Exact sum per plane; a negative total rejects the box.
  for (genvar gp = 0; gp < NumPlanes; gp++) begin : g_sum
    logic signed [SumW-1:0] acc;
    assign acc = SumW'(terms_r[gp].p[0]) + SumW'(terms_r[gp].p[1])
               + SumW'(terms_r[gp].p[2]) + (SumW'(terms_r[gp].w) <<< WShift);
    assign plane_ok[gp] = ~acc[SumW-1];
  end

  assign visible       = &plane_ok;
  assign ctl_out.en    = ctl_in.en;
  assign ctl_out.valid = valid_r;

endmodule

>>> rtl/frustum_box_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_box_cull_top
// Frustum culling of axis-aligned boxes against a loaded 4x4 matrix.
// ----------------------------------------------------------------------------
// Path: a test word passes the input, plane, product and output registers in
// turn; a load word writes the matrix at acceptance and gives no result.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and not taken, so in_tready follows out_tready while full.
// Reset: synchronous active-low rst_n empties the pipeline and clears the
// matrix to zero, after which every box is visible.
module frustum_box_cull_top
  import fbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // entry_index[3:0], entry_value[27:4], min_x[51:28], min_y[75:52],
  // min_z[99:76], max_x[123:100], max_y[147:124], max_z[171:148], zero fill
  input  logic [InDataW-1:0]  in_tdata,
  // op[0]
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // visible[0], zero fill
  output logic [OutDataW-1:0] out_tdata
);

  logic        en;
  logic        in_acc;
  op_t         op;
  box_t        box_nxt;
  box_t        box_r;
  logic        in_valid_r;
  mat_t        mat;
  plane_set_t  planes;
  stage_ctl_t  ctl_s1;
  stage_ctl_t  ctl_s2;
  stage_ctl_t  ctl_s3;
  logic        visible;
  logic        out_valid_r;
  logic        visible_r;

  // Global stall: advance whenever the output register can move.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;
  assign op        = op_t'(in_tuser);

  // Unpack the box corners.
  assign box_nxt.lo[0] = in_tdata[51:28];
  assign box_nxt.lo[1] = in_tdata[75:52];
  assign box_nxt.lo[2] = in_tdata[99:76];
  assign box_nxt.hi[0] = in_tdata[123:100];
  assign box_nxt.hi[1] = in_tdata[147:124];
  assign box_nxt.hi[2] = in_tdata[171:148];

  // Load words write the matrix directly at acceptance.
  fbc_matrix_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (in_acc && (op == OP_LOAD)),
    .waddr (in_tdata[3:0]),
    .wdata (in_tdata[27:4]),
    .mat   (mat)
  );

  // Input register: only test words enter the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_tvalid && (op == OP_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_r <= box_nxt;
    end
  end

  assign ctl_s1.en    = en;
  assign ctl_s1.valid = in_valid_r;

  fbc_plane_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_s1),
    .mat     (mat),
    .box     (box_r),
    .ctl_out (ctl_s2),
    .planes  (planes)
  );

  fbc_plane_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl_s2),
    .planes  (planes),
    .ctl_out (ctl_s3),
    .visible (visible)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_s3.en) begin
      out_valid_r <= ctl_s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_s3.en) begin
      visible_r <= visible;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-1){1'b0}}, visible_r};

endmodule

>>> dv/tb_frustum_box_cull_top.sv
// ----------------------------------------------------------------------------
// tb_frustum_box_cull_top
// Self-checking bench for the frustum box culling block. Matrix load words
// and box test words go in on the input stream. A software copy of the
// matrix store predicts the visible flag of every test word as it is
// accepted. The monitor checks each output word against the oldest flag
// waiting. Sender and receiver idle at random in several mixes, and the
// output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull_top
  import fbc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordMin = -(2 ** (CoordW - 1));
  localparam int CoordMax = (2 ** (CoordW - 1)) - 1;
  localparam int StallCycles = 80;

  // Kinds of matrix that a random segment loads.
  typedef enum int {
    MK_FRUSTUM,
    MK_RANDOM,
    MK_SPARSE
  } matrix_kind_t;

  // One input word before packing.
  typedef struct {
    op_t              op;
    logic [IdxW-1:0]  idx;
    entry_t           val;
    coord_t           min_x, min_y, min_z;
    coord_t           max_x, max_y, max_z;
  } cull_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  // Words still to send, the word on the bus, and the flags still to come.
  cull_word_t word_queue[$];
  cull_word_t offered;
  bit         vis_expect[$];
  bit         exp_vis;

  // Matrix copy, mirrored at every accepted load word.
  entry_t     mat_copy[MatEntries] = '{default: '0};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_reqs = 0;
  int stall_seen = 0;
  int hold_left = 0;

  int n_errors = 0;
  int n_loads = 0;
  int n_tests = 0;
  int n_visible = 0;
  int n_culled = 0;

  frustum_box_cull_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // A box is visible unless some clip plane has its positive vertex behind it.
  function automatic bit box_in_view(input cull_word_t w);
    longint lo[NumAxes];
    longint hi[NumAxes];
    longint acc, nrm, wt, r3, rr;
    int     row;
    lo[0] = w.min_x;
    lo[1] = w.min_y;
    lo[2] = w.min_z;
    hi[0] = w.max_x;
    hi[1] = w.max_y;
    hi[2] = w.max_z;
    for (int p = 0; p < NumPlanes; p++) begin
      // Planes come in pairs: row 3 plus, then minus, row 0, 1 and 2.
      row = p / 2;
      acc = 0;
      for (int ax = 0; ax < NumAxes; ax++) begin
        r3 = mat_copy[ax * 4 + 3];
        rr = mat_copy[ax * 4 + row];
        nrm = (p % 2 == 1) ? r3 - rr : r3 + rr;
        acc += nrm * ((nrm >= 0) ? hi[ax] : lo[ax]);
      end
      r3 = mat_copy[3 * 4 + 3];
      rr = mat_copy[3 * 4 + row];
      wt = (p % 2 == 1) ? r3 - rr : r3 + rr;
      acc += wt <<< WShift;
      if (acc < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic entry_t rnd_entry();
    return entry_t'($urandom);
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(4))
      0: return CoordMin;
      1: return CoordMax;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_load(input int idx, input entry_t val);
    cull_word_t w;
    w.op = OP_LOAD;
    w.idx = IdxW'(idx);
    w.val = val;
    // The box fields of a load word are ignored, so they carry noise.
    w.min_x = coord_t'($urandom);
    w.min_y = coord_t'($urandom);
    w.min_z = coord_t'($urandom);
    w.max_x = coord_t'($urandom);
    w.max_y = coord_t'($urandom);
    w.max_z = coord_t'($urandom);
    word_queue.push_back(w);
  endtask

  task automatic push_test(input int x0, input int y0, input int z0,
                           input int x1, input int y1, input int z1);
    cull_word_t w;
    w.op = OP_TEST;
    w.idx = IdxW'($urandom);
    w.val = rnd_entry();
    w.min_x = coord_t'(x0);
    w.min_y = coord_t'(y0);
    w.min_z = coord_t'(z0);
    w.max_x = coord_t'(x1);
    w.max_y = coord_t'(y1);
    w.max_z = coord_t'(z1);
    word_queue.push_back(w);
  endtask

  // Random box: mostly sized around the frustum, sometimes extreme or noise.
  task automatic push_random_box();
    int lo[NumAxes];
    int hi[NumAxes];
    int scale, c, h, t;
    for (int ax = 0; ax < NumAxes; ax++) begin
      case ($urandom_range(9))
        0: begin
          lo[ax] = pick_extreme();
          hi[ax] = pick_extreme();
        end
        1: begin
          lo[ax] = $urandom;
          hi[ax] = $urandom;
        end
        default: begin
          scale = $urandom_range(1) ? $urandom_range(12, 6) : $urandom_range(23, 4);
          c = int'($urandom_range((1 << scale) - 1)) - (1 << (scale - 1));
          h = $urandom_range((1 << scale) - 1) >> 1;
          lo[ax] = c - h;
          hi[ax] = c + h;
        end
      endcase
      // Now and then the box is turned inside out on this axis.
      if ($urandom_range(7) == 0) begin
        t = lo[ax];
        lo[ax] = hi[ax];
        hi[ax] = t;
      end
    end
    push_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Full matrix load, all sixteen entries in store order.
  task automatic push_matrix(input matrix_kind_t kind);
    entry_t v;
    int     col, row;
    for (int i = 0; i < MatEntries; i++) begin
      col = i / 4;
      row = i % 4;
      case (kind)
        MK_FRUSTUM: begin
          // Scaled diagonal with small skew, positive w: a sensible frustum.
          if (col == row && row < 3) begin
            v = entry_t'($urandom_range(1 << 17, 1 << 12));
            if ($urandom_range(4) == 0) v = -v;
          end else if (col == 3 && row == 3) begin
            v = entry_t'($urandom_range(1 << 18, 1 << 14));
          end else begin
            v = entry_t'(int'($urandom_range(1 << 14)) - (1 << 13));
          end
        end
        MK_RANDOM: v = rnd_entry();
        default:   v = $urandom_range(1) ? rnd_entry() : '0;
      endcase
      push_load(i, v);
    end
  endtask

  // Segments of one matrix followed by a run of boxes, with stray loads.
  task automatic fill_phase(input int n_words);
    int start, n_box;
    start = word_queue.size();
    while (word_queue.size() - start < n_words) begin
      push_matrix(matrix_kind_t'($urandom_range(2)));
      n_box = $urandom_range(40, 15);
      repeat (n_box) begin
        if ($urandom_range(19) == 0) push_load($urandom_range(MatEntries - 1), rnd_entry());
        push_random_box();
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (word_queue.size() != 0 || in_tvalid || vis_expect.size() != 0) @(negedge clk);
  endtask

  // Driver: predicts each accepted word, then offers the next one or idles.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      if (offered.op == OP_LOAD) begin
        mat_copy[offered.idx] = offered.val;
        n_loads++;
      end else begin
        vis_expect.push_back(box_in_view(offered));
        n_tests++;
      end
    end
    if (!in_tvalid || in_tready) begin
      if (rst_n && word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = word_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {4'b0, offered.max_z, offered.max_y, offered.max_x,
                     offered.min_z, offered.min_y, offered.min_x,
                     offered.val, offered.idx};
        in_tuser <= offered.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each output word and drives the output back-pressure.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (vis_expect.size() == 0) begin
        report_mismatch($sformatf("visible=%0b with no box test outstanding", out_tdata[0]));
      end else begin
        exp_vis = vis_expect.pop_front();
        if (out_tdata[0] !== exp_vis)
          report_mismatch($sformatf("visible=%0b, expected %0b", out_tdata[0], exp_vis));
        if (exp_vis) n_visible++;
        else n_culled++;
      end
    end
    // A long hold-off starts whenever the sequence asks for one.
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      hold_left = StallCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sequence: reset, directed cases, a long output stall, then random phases.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 54;

    // All-zero matrix after reset: any box is visible, even an inverted one.
    push_test(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    push_test(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin);
    // Zero normals: only the sign of the w term decides.
    push_load(3 * 4 + 3, -1);
    push_test(0, 0, 0, 0, 0, 0);
    push_load(3 * 4 + 3, CoordMax);
    push_test(-1, -1, -1, 1, 1, 1);
    push_load(3 * 4 + 0, CoordMin);
    push_test(0, 0, 0, 0, 0, 0);
    push_load(3 * 4 + 0, 0);
    // Unit x scale with unit w: boxes inside, outside and on the right plane.
    push_load(3 * 4 + 3, 1 << 16);
    push_load(0 * 4 + 0, 1 << 16);
    push_test(-256, 0, 0, 256, 0, 0);
    push_test(512, 0, 0, 1024, 0, 0);
    push_test(256, -5, -5, 300, 5, 5);
    push_test(257, -5, -5, 300, 5, 5);
    // Extreme matrix entries against extreme boxes.
    push_load(0 * 4 + 0, CoordMin);
    push_load(1 * 4 + 3, CoordMax);
    push_load(2 * 4 + 3, CoordMax);
    push_test(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
    push_test(CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin);
    push_test(0, 0, 0, 0, 0, 0);
    wait_drained();

    // Output held off while the sender keeps offering, so the input stalls.
    send_idle_pct = 0;
    stall_reqs++;
    repeat (24) push_random_box();
    wait_drained();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      fill_phase(400);
      wait_drained();
    end

    repeat (8) @(negedge clk);
    $display("Covered %0d matrix load words and %0d box test words (%0d visible, %0d culled),",
             n_loads, n_tests, n_visible, n_culled);
    $display("with corner boxes, a long output stall and three idling mixes.");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fbc_pkg.sv
rtl/fbc_matrix_store.sv
rtl/fbc_plane_setup.sv
rtl/fbc_plane_eval.sv
rtl/frustum_box_cull_top.sv
dv/tb_frustum_box_cull_top.sv
